// ===== src/rfp_pkg.sv =====
// rfp_pkg.sv: shared types and constants of the response frame parser
`timescale 1ns / 1ps
package rfp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_PRE   = 4'd1,
    PH_SC1   = 4'd2,
    PH_SC2   = 4'd3,
    PH_LEN   = 4'd4,
    PH_LCS   = 4'd5,
    PH_TFI   = 4'd6,
    PH_CODE  = 4'd7,
    PH_DATA  = 4'd8,
    PH_DCS   = 4'd9,
    PH_POST  = 4'd10,
    PH_DRAIN = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_e;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
  localparam logic [7:0] START1_BYTE   = 8'h00;
  localparam logic [7:0] START2_BYTE   = 8'hFF;
  localparam logic [7:0] TO_HOST_BYTE  = 8'hD5;
  localparam logic [7:0] MIN_LEN       = 8'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [1:0] status;
    logic [7:0] payload_length;
  } result_t;

endpackage

// ===== src/rfp_in_if.sv =====
// rfp_in_if.sv: input channel carrying start and received byte items
`timescale 1ns / 1ps
interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic [7:0] expected_command;
  logic [7:0] capacity;

  modport source (output valid, output op, output rx_byte, output expected_command,
                  output capacity, input ready);
  modport sink (input valid, input op, input rx_byte, input expected_command,
                input capacity, output ready);
endinterface

// ===== src/rfp_out_if.sv =====
// rfp_out_if.sv: output channel carrying payload bytes and frame status
`timescale 1ns / 1ps
interface rfp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [1:0] status;
  logic [7:0] payload_length;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output status, output payload_length, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input status, input payload_length, output ready);
endinterface

// ===== src/response_frame_parser_unit.sv =====
// response_frame_parser_unit.sv: top level of the response frame parser
// Takes one item per clock cycle, a start item or one received frame byte, and
// checks the frame header, length checksum, direction byte, reply code and data
// checksum as the bytes arrive. Each byte is handled in the cycle it is accepted
// and its result, a payload byte or the final frame status, appears in the output
// register on the next cycle. The output register is the only stage, so ready
// falls only while a result is held and the sink is not taking it; with the sink
// ready the block sustains one item per cycle.
`timescale 1ns / 1ps
module response_frame_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfp_in_if.sink      in_i,
  rfp_out_if.source   out_o
);

  rfp_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       remaining_q, remaining_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       exp_code_q, exp_code_d;
  logic [7:0]       room_q, room_d;
  logic [7:0]       index_q, index_d;
  logic             overflow_q, overflow_d;
  logic [7:0]       length_q, length_d;

  logic             out_valid_q, out_valid_d;
  rfp_pkg::result_t res_q, res_d;
  logic             res_valid;
  logic             in_acc;
  logic [7:0]       pay_len;
  logic [7:0]       rem_dec;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign pay_len    = length_q - rfp_pkg::MIN_LEN;
  assign rem_dec    = remaining_q - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    sum_d       = sum_q;
    exp_code_d  = exp_code_q;
    room_d      = room_q;
    index_d     = index_q;
    overflow_d  = overflow_q;
    length_d    = length_q;
    res_valid   = 1'b0;
    res_d       = '0;
    if (in_i.op == rfp_pkg::OP_START) begin
      exp_code_d  = in_i.expected_command + 8'd1;
      room_d      = in_i.capacity;
      remaining_d = '0;
      sum_d       = '0;
      index_d     = '0;
      overflow_d  = 1'b0;
      length_d    = '0;
      phase_d     = rfp_pkg::PH_PRE;
    end else begin
      unique case (phase_q)
        rfp_pkg::PH_PRE: begin
          if (in_i.rx_byte != rfp_pkg::PREAMBLE_BYTE) begin
            res_valid = 1'b1;
          end else begin
            phase_d = rfp_pkg::PH_SC1;
          end
        end
        rfp_pkg::PH_SC1: begin
          if (in_i.rx_byte != rfp_pkg::START1_BYTE) begin
            res_valid = 1'b1;
          end else begin
            phase_d = rfp_pkg::PH_SC2;
          end
        end
        rfp_pkg::PH_SC2: begin
          if (in_i.rx_byte != rfp_pkg::START2_BYTE) begin
            res_valid = 1'b1;
          end else begin
            phase_d = rfp_pkg::PH_LEN;
          end
        end
        rfp_pkg::PH_LEN: begin
          length_d = in_i.rx_byte;
          phase_d  = rfp_pkg::PH_LCS;
        end
        rfp_pkg::PH_LCS: begin
          if ((length_q + in_i.rx_byte) != 8'd0 || length_q < rfp_pkg::MIN_LEN) begin
            res_valid = 1'b1;
          end else begin
            phase_d = rfp_pkg::PH_TFI;
          end
        end
        rfp_pkg::PH_TFI: begin
          if (in_i.rx_byte != rfp_pkg::TO_HOST_BYTE) begin
            res_valid = 1'b1;
          end else begin
            phase_d = rfp_pkg::PH_CODE;
          end
        end
        rfp_pkg::PH_CODE: begin
          if (in_i.rx_byte != exp_code_q) begin
            res_valid = 1'b1;
          end else begin
            index_d = '0;
            sum_d   = rfp_pkg::TO_HOST_BYTE + in_i.rx_byte;
            if (pay_len > room_q) begin
              overflow_d  = 1'b1;
              remaining_d = length_q;
              phase_d     = rfp_pkg::PH_DRAIN;
            end else begin
              remaining_d = pay_len;
              phase_d     = (pay_len == 8'd0) ? rfp_pkg::PH_DCS : rfp_pkg::PH_DATA;
            end
          end
        end
        rfp_pkg::PH_DATA: begin
          res_valid       = 1'b1;
          res_d.kind      = rfp_pkg::KIND_DATA;
          res_d.data_byte = in_i.rx_byte;
          res_d.byte_index = index_q;
          sum_d       = sum_q + in_i.rx_byte;
          index_d     = index_q + 8'd1;
          remaining_d = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_d = rfp_pkg::PH_DCS;
          end
        end
        rfp_pkg::PH_DCS: begin
          if ((sum_q + in_i.rx_byte) != 8'd0) begin
            res_valid = 1'b1;
          end else begin
            phase_d = rfp_pkg::PH_POST;
          end
        end
        rfp_pkg::PH_POST: begin
          res_valid            = 1'b1;
          res_d.status         = rfp_pkg::ST_OK;
          res_d.payload_length = index_q;
        end
        rfp_pkg::PH_DRAIN: begin
          remaining_d = rem_dec;
          if (rem_dec == 8'd0) begin
            res_valid    = 1'b1;
            res_d.status = rfp_pkg::ST_NOSPACE;
          end
        end
        default: begin
          phase_d = rfp_pkg::PH_IDLE;
        end
      endcase
      // every result except a payload byte is a status that closes the frame
      if (res_valid && phase_q != rfp_pkg::PH_DATA) begin
        res_d.kind = rfp_pkg::KIND_STATUS;
        phase_d    = rfp_pkg::PH_IDLE;
        if (phase_q != rfp_pkg::PH_POST && phase_q != rfp_pkg::PH_DRAIN) begin
          res_d.status = rfp_pkg::ST_INVALID;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rfp_pkg::PH_IDLE;
      remaining_q <= '0;
      sum_q       <= '0;
      exp_code_q  <= '0;
      room_q      <= '0;
      index_q     <= '0;
      overflow_q  <= 1'b0;
      length_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q     <= phase_d;
        remaining_q <= remaining_d;
        sum_q       <= sum_d;
        exp_code_q  <= exp_code_d;
        room_q      <= room_d;
        index_q     <= index_d;
        overflow_q  <= overflow_d;
        length_q    <= length_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = res_q.kind;
  assign out_o.data_byte      = res_q.data_byte;
  assign out_o.byte_index     = res_q.byte_index;
  assign out_o.status         = res_q.status;
  assign out_o.payload_length = res_q.payload_length;

  a_start_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.op == rfp_pkg::OP_START |=> !out_valid_q)
    else $error("start item produced a result");

  a_status_ends_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_valid && res_d.kind == rfp_pkg::KIND_STATUS |=>
      phase_q == rfp_pkg::PH_IDLE)
    else $error("parser not idle after frame status");

  a_drain_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rfp_pkg::PH_DRAIN |-> overflow_q)
    else $error("draining without overflow");

  a_data_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == rfp_pkg::KIND_DATA |->
      res_q.status == rfp_pkg::ST_OK && res_q.payload_length == 8'd0)
    else $error("payload item carries status fields");

  a_data_phase_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rfp_pkg::PH_DATA |-> remaining_q != 8'd0 && !overflow_q)
    else $error("payload phase with nothing left");

endmodule
